/* rtl/ps2m_pkg.sv */
// Shared types and constants for the PS/2 mouse packet decoder.
package ps2m_pkg;

    // Cursor coordinate width used when the top level is not overridden.
    localparam int COORD_BITS_DEF = 12;

    // Limit registers and their reset values.
    localparam int LIMIT_BITS = 12;
    localparam logic [LIMIT_BITS-1:0] X_LIMIT_RST = 12'd1023;
    localparam logic [LIMIT_BITS-1:0] Y_LIMIT_RST = 12'd767;

    // Configuration register indexes.
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_X_LIMIT = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_Y_LIMIT = 2'd1;

    // Header byte layout.
    localparam int BTN_BITS  = 3;
    localparam int HDR_LEFT  = 0;
    localparam int HDR_XSIGN = 4;
    localparam int HDR_YSIGN = 5;

    // Delta width: sign bit from the header plus the data byte.
    localparam int DELTA_BITS = 9;

    // Event codes on the result channel.
    typedef enum logic [1:0] {
        EV_MOVE     = 2'd0,
        EV_BTN_DOWN = 2'd1,
        EV_BTN_UP   = 2'd2
    } ev_kind_t;

    // A complete packet handed from the byte assembler to the cursor stage.
    typedef struct packed {
        logic       fire;
        logic [7:0] hdr;
        logic [7:0] xb;
        logic [7:0] yb;
    } pkt_t;

endpackage

/* rtl/ps2_mouse_packet_to_cursor_top.sv */
// Top level of the PS/2 mouse packet decoder with clamped cursor.
// Path: the third byte waits in the input register, then its move event enters the result register.
// Throughput: one byte per cycle while the output has room; a packet with a left button edge
// fills the result register and the pending slot, which stalls a following final byte until free.
// Reset: cursor at the origin, buttons released, packet phase at the header,
// limits at 1023 and 767; no clearing pass, transfers are taken right after reset.
module ps2_mouse_packet_to_cursor_top #(
    parameter int COORD_BITS = ps2m_pkg::COORD_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [7:0]                             rx_byte,
    input  logic                                   from_aux,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [1:0]                             event_kind,
    output logic [COORD_BITS-1:0]                  cursor_x,
    output logic [COORD_BITS-1:0]                  cursor_y,
    output logic signed [ps2m_pkg::DELTA_BITS-1:0] delta_x,
    output logic signed [ps2m_pkg::DELTA_BITS-1:0] delta_y,
    output logic                                   button_id,
    output logic                                   last_event,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [ps2m_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [ps2m_pkg::LIMIT_BITS-1:0]        cfg_data
);

    logic [ps2m_pkg::LIMIT_BITS-1:0] x_limit_reg;
    logic [ps2m_pkg::LIMIT_BITS-1:0] y_limit_reg;
    logic                            room;
    ps2m_pkg::pkt_t                  pkt;

    // Configuration writes are always taken; unknown indexes are ignored.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_limit_reg <= ps2m_pkg::X_LIMIT_RST;
            y_limit_reg <= ps2m_pkg::Y_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == ps2m_pkg::CFG_X_LIMIT)
            begin
                x_limit_reg <= cfg_data;
            end
            else if (cfg_index == ps2m_pkg::CFG_Y_LIMIT)
            begin
                y_limit_reg <= cfg_data;
            end
        end
    end

    // Byte input register and packet assembly.
    ps2m_assembler u_assembler (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .rx_byte  (rx_byte),
        .from_aux (from_aux),
        .room     (room),
        .pkt      (pkt)
    );

    // Cursor update and result register.
    ps2m_cursor #(
        .COORD_BITS (COORD_BITS)
    ) u_cursor (
        .clk        (clk),
        .rst_n      (rst_n),
        .pkt        (pkt),
        .x_limit    (x_limit_reg),
        .y_limit    (y_limit_reg),
        .room       (room),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .event_kind (event_kind),
        .cursor_x   (cursor_x),
        .cursor_y   (cursor_y),
        .delta_x    (delta_x),
        .delta_y    (delta_y),
        .button_id  (button_id),
        .last_event (last_event)
    );

`ifndef SYNTHESIS
    // A result that is not the last of its packet is always the move event.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_event |-> event_kind == ps2m_pkg::EV_MOVE)
        else $error("non-final result is not a move event");

    // Button events carry no movement and always close the packet.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && button_id |-> delta_x == '0 && delta_y == '0 && last_event)
        else $error("button event with movement or not final");

    // The button event follows its move event in the very next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_event |=> out_valid && button_id)
        else $error("button event did not follow its move event");
`endif

endmodule

/* rtl/ps2m_assembler.sv */
// Input register and three-byte packet assembly.
module ps2m_assembler (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [7:0]      rx_byte,
    input  logic            from_aux,
    input  logic            room,
    output ps2m_pkg::pkt_t  pkt
);

    // Position within the packet, one-hot.
    typedef enum logic [2:0] {
        PH_HDR = 3'b001,
        PH_X   = 3'b010,
        PH_Y   = 3'b100
    } phase_t;

    logic       a_valid_reg, a_valid_next;
    logic [7:0] a_byte_reg;
    phase_t     phase_reg, phase_next;
    logic [7:0] hdr_reg, hdr_next;
    logic [7:0] xb_reg, xb_next;
    logic       in_xfer;
    logic       complete;
    logic       advance;

    // The held byte moves on unless it completes a packet and the output is full.
    assign complete = (phase_reg == PH_Y);
    assign advance  = a_valid_reg && (!complete || room);
    assign in_ready = !a_valid_reg || advance;
    assign in_xfer  = in_valid && in_ready;

    assign pkt.fire = advance && complete;
    assign pkt.hdr  = hdr_reg;
    assign pkt.xb   = xb_reg;
    assign pkt.yb   = a_byte_reg;

    // Input register: bytes from the keyboard port are dropped at the transfer.
    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (in_xfer)
        begin
            a_valid_next = from_aux;
        end
        else if (advance)
        begin
            a_valid_next = 1'b0;
        end
    end

    // Packet phase and held header and X bytes.
    always_comb
    begin
        phase_next = phase_reg;
        hdr_next   = hdr_reg;
        xb_next    = xb_reg;
        if (advance)
        begin
            case (phase_reg)
                PH_HDR:
                begin
                    hdr_next   = a_byte_reg;
                    phase_next = PH_X;
                end
                PH_X:
                begin
                    xb_next    = a_byte_reg;
                    phase_next = PH_Y;
                end
                PH_Y:
                begin
                    phase_next = PH_HDR;
                end
                default:
                begin
                    // A damaged phase restarts the packet with this byte as header.
                    hdr_next   = a_byte_reg;
                    phase_next = PH_X;
                end
            endcase
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            phase_reg   <= PH_HDR;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            phase_reg   <= phase_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            a_byte_reg <= rx_byte;
        end
        hdr_reg <= hdr_next;
        xb_reg  <= xb_next;
    end

endmodule

/* rtl/ps2m_cursor.sv */
// Cursor update, button edge detection and the result register.
module ps2m_cursor #(
    parameter int COORD_BITS = ps2m_pkg::COORD_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  ps2m_pkg::pkt_t                         pkt,
    input  logic [ps2m_pkg::LIMIT_BITS-1:0]        x_limit,
    input  logic [ps2m_pkg::LIMIT_BITS-1:0]        y_limit,
    output logic                                   room,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [1:0]                             event_kind,
    output logic [COORD_BITS-1:0]                  cursor_x,
    output logic [COORD_BITS-1:0]                  cursor_y,
    output logic signed [ps2m_pkg::DELTA_BITS-1:0] delta_x,
    output logic signed [ps2m_pkg::DELTA_BITS-1:0] delta_y,
    output logic                                   button_id,
    output logic                                   last_event
);

    localparam int DB = ps2m_pkg::DELTA_BITS;

    logic [COORD_BITS-1:0]            pos_x_reg, pos_x_next;
    logic [COORD_BITS-1:0]            pos_y_reg, pos_y_next;
    logic [ps2m_pkg::BTN_BITS-1:0]    prev_btn_reg;
    logic                             out_valid_reg, out_valid_next;
    logic                             pend_valid_reg, pend_valid_next;
    ps2m_pkg::ev_kind_t               pend_kind_reg;
    ps2m_pkg::ev_kind_t               out_kind_reg;
    logic signed [DB-1:0]             dx_reg;
    logic signed [DB-1:0]             dy_reg;
    logic                             btn_reg;
    logic                             last_reg;
    logic signed [DB-1:0]             dx;
    logic signed [DB-1:0]             dy;
    logic [COORD_BITS-1:0]            lim_x;
    logic [COORD_BITS-1:0]            lim_y;
    ps2m_pkg::ev_kind_t               kind;
    logic                             out_xfer;

    // Add a signed delta and clamp the sum to zero and the limit.
    function automatic logic [COORD_BITS-1:0] clamp_add(
        input logic [COORD_BITS-1:0] pos,
        input logic signed [DB-1:0]  d,
        input logic [COORD_BITS-1:0] lim
    );
        logic signed [COORD_BITS+1:0] sum;
        logic [COORD_BITS-1:0]        res;
        sum = $signed({2'b00, pos}) + $signed((COORD_BITS+2)'(d));
        if (sum[COORD_BITS+1])
        begin
            res = '0;
        end
        else if (sum[COORD_BITS:0] > {1'b0, lim})
        begin
            res = lim;
        end
        else
        begin
            res = sum[COORD_BITS-1:0];
        end
        return res;
    endfunction

    // Deltas are 9-bit two's complement with the sign bit from the header.
    assign dx    = $signed({pkt.hdr[ps2m_pkg::HDR_XSIGN], pkt.xb});
    assign dy    = $signed({pkt.hdr[ps2m_pkg::HDR_YSIGN], pkt.yb});
    assign lim_x = COORD_BITS'(x_limit);
    assign lim_y = COORD_BITS'(y_limit);

    assign pos_x_next = clamp_add(pos_x_reg, dx, lim_x);
    assign pos_y_next = clamp_add(pos_y_reg, dy, lim_y);

    // Left button edge gives the optional second event.
    always_comb
    begin
        kind = ps2m_pkg::EV_MOVE;
        if (pkt.hdr[ps2m_pkg::HDR_LEFT] && !prev_btn_reg[ps2m_pkg::HDR_LEFT])
        begin
            kind = ps2m_pkg::EV_BTN_DOWN;
        end
        else if (!pkt.hdr[ps2m_pkg::HDR_LEFT] && prev_btn_reg[ps2m_pkg::HDR_LEFT])
        begin
            kind = ps2m_pkg::EV_BTN_UP;
        end
    end

    // A new packet needs both the result register and the pending slot free.
    assign out_xfer = out_valid_reg && out_ready;
    assign room     = !pend_valid_reg && (!out_valid_reg || out_ready);

    // Result register and pending button event.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        pend_valid_next = pend_valid_reg;
        if (pkt.fire)
        begin
            out_valid_next  = 1'b1;
            pend_valid_next = (kind != ps2m_pkg::EV_MOVE);
        end
        else if (out_xfer)
        begin
            out_valid_next  = pend_valid_reg;
            pend_valid_next = 1'b0;
        end
    end

    // Control and architectural state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg      <= '0;
            pos_y_reg      <= '0;
            prev_btn_reg   <= '0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
            if (pkt.fire)
            begin
                pos_x_reg    <= pos_x_next;
                pos_y_reg    <= pos_y_next;
                prev_btn_reg <= pkt.hdr[ps2m_pkg::BTN_BITS-1:0];
            end
        end
    end

    // Result payload: the move event first, the button event from the pending slot.
    always_ff @(posedge clk)
    begin
        if (pkt.fire)
        begin
            out_kind_reg  <= ps2m_pkg::EV_MOVE;
            dx_reg        <= dx;
            dy_reg        <= dy;
            btn_reg       <= 1'b0;
            last_reg      <= (kind == ps2m_pkg::EV_MOVE);
            pend_kind_reg <= kind;
        end
        else if (out_xfer && pend_valid_reg)
        begin
            out_kind_reg <= pend_kind_reg;
            dx_reg       <= '0;
            dy_reg       <= '0;
            btn_reg      <= 1'b1;
            last_reg     <= 1'b1;
        end
    end

    // The position only moves when a packet enters, so it drives the ports directly.
    assign out_valid  = out_valid_reg;
    assign event_kind = out_kind_reg;
    assign cursor_x   = pos_x_reg;
    assign cursor_y   = pos_y_reg;
    assign delta_x    = dx_reg;
    assign delta_y    = dy_reg;
    assign button_id  = btn_reg;
    assign last_event = last_reg;

endmodule

/* tb/tb_ps2_mouse_packet_to_cursor_top.sv */
// Self-checking testbench for the PS/2 mouse packet decoder with clamped cursor.
module tb_ps2_mouse_packet_to_cursor_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ps2m_pkg::*;

    localparam int CB = COORD_BITS_DEF;
    localparam int ITEMS_PER_PHASE = 130;
    localparam int NUM_PHASES = 10;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 6;
    localparam int RANDOM_LIMIT = -1;

    // Register indexes the block does not decode; writes there must be ignored.
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_SPARE_B = 2'd3;

    typedef enum int {READY_ALWAYS, READY_RANDOM, READY_PATTERN} ready_style_t;
    typedef enum int {DRIFT_NONE, DRIFT_UP, DRIFT_DOWN} drift_t;

    // Limit settings and cursor drift for each random phase.
    localparam int X_LIMIT_PLAN [NUM_PHASES] =
        '{4095, 0, 4095, 0, 17, RANDOM_LIMIT, RANDOM_LIMIT, 4095, 100, 1023};
    localparam int Y_LIMIT_PLAN [NUM_PHASES] =
        '{4095, 0, 0, 4095, 9, RANDOM_LIMIT, RANDOM_LIMIT, 4095, 50, 767};
    localparam drift_t DRIFT_PLAN [NUM_PHASES] =
        '{DRIFT_UP, DRIFT_NONE, DRIFT_DOWN, DRIFT_UP, DRIFT_NONE,
          DRIFT_NONE, DRIFT_DOWN, DRIFT_UP, DRIFT_NONE, DRIFT_DOWN};

    typedef struct packed {
        logic [7:0] data;
        logic       aux;
    } mouse_byte_t;

    typedef struct {
        ev_kind_t                     kind;
        logic [CB-1:0]                cx;
        logic [CB-1:0]                cy;
        logic signed [DELTA_BITS-1:0] dx;
        logic signed [DELTA_BITS-1:0] dy;
        logic                         btn;
        logic                         last;
    } cursor_event_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_ready;
    logic [7:0]                   rx_byte = 8'd0;
    logic                         from_aux = 1'b0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic [1:0]                   event_kind;
    logic [CB-1:0]                cursor_x;
    logic [CB-1:0]                cursor_y;
    logic signed [DELTA_BITS-1:0] delta_x;
    logic signed [DELTA_BITS-1:0] delta_y;
    logic                         button_id;
    logic                         last_event;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [CFG_IDX_BITS-1:0]      cfg_index = CFG_X_LIMIT;
    logic [LIMIT_BITS-1:0]        cfg_data = '0;

    ps2_mouse_packet_to_cursor_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .from_aux   (from_aux),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .event_kind (event_kind),
        .cursor_x   (cursor_x),
        .cursor_y   (cursor_y),
        .delta_x    (delta_x),
        .delta_y    (delta_y),
        .button_id  (button_id),
        .last_event (last_event),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // Bytes waiting to be sent and events the cursor predictor still expects.
    mouse_byte_t   pending_bytes [$];
    cursor_event_t expected_events [$];

    // Predictor state: packet framing, cursor, buttons and limits.
    logic [1:0]          pkt_phase = 2'd0;
    logic [7:0]          hdr_byte = 8'd0;
    logic [7:0]          x_byte = 8'd0;
    logic [CB-1:0]       cur_x = '0;
    logic [CB-1:0]       cur_y = '0;
    logic [BTN_BITS-1:0] prev_btns = '0;
    logic [CB-1:0]       x_lim = X_LIMIT_RST;
    logic [CB-1:0]       y_lim = Y_LIMIT_RST;

    // Traffic shaping, shared between the stimulus and the clocked drivers.
    bit           sender_bursty = 1'b1;
    ready_style_t ready_style = READY_RANDOM;
    bit           in_fire = 1'b0;

    int mismatch_count = 0;
    int bytes_taken = 0;
    int bytes_ignored = 0;
    int moves_checked = 0;
    int buttons_checked = 0;
    int limit_writes = 0;
    int idle_cycles = 0;

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic logic [CB-1:0] clamp_coord(input logic [CB-1:0] pos,
                                                  input int delta,
                                                  input logic [CB-1:0] lim);
        int p;
        int l;
        int v;
        p = int'(pos);
        l = int'(lim);
        v = p + delta;
        if (v < 0)
            v = 0;
        if (v > l)
            v = l;
        return v[CB-1:0];
    endfunction

    // Frame one accepted byte and queue the events a finished packet produces.
    task automatic absorb_byte(input logic [7:0] b, input logic aux);
        int                  dx;
        int                  dy;
        logic [BTN_BITS-1:0] btns;
        ev_kind_t            btn_change;
        cursor_event_t       ev;
        if (!aux) begin
            bytes_ignored++;
            return;
        end
        if (pkt_phase == 2'd1) begin
            x_byte = b;
            pkt_phase = 2'd2;
            return;
        end
        if (pkt_phase != 2'd2) begin
            hdr_byte = b;
            pkt_phase = 2'd1;
            return;
        end
        pkt_phase = 2'd0;
        dx = int'(x_byte) - (hdr_byte[HDR_XSIGN] ? 256 : 0);
        dy = int'(b) - (hdr_byte[HDR_YSIGN] ? 256 : 0);
        cur_x = clamp_coord(cur_x, dx, x_lim);
        cur_y = clamp_coord(cur_y, dy, y_lim);

        // Only the left button produces a second event.
        btns = hdr_byte[BTN_BITS-1:0];
        btn_change = EV_MOVE;
        if (btns[HDR_LEFT] && !prev_btns[HDR_LEFT])
            btn_change = EV_BTN_DOWN;
        else if (!btns[HDR_LEFT] && prev_btns[HDR_LEFT])
            btn_change = EV_BTN_UP;
        prev_btns = btns;

        ev.kind = EV_MOVE;
        ev.cx = cur_x;
        ev.cy = cur_y;
        ev.dx = dx[DELTA_BITS-1:0];
        ev.dy = dy[DELTA_BITS-1:0];
        ev.btn = 1'b0;
        ev.last = (btn_change == EV_MOVE);
        expected_events.push_back(ev);
        if (btn_change != EV_MOVE) begin
            ev.kind = btn_change;
            ev.dx = '0;
            ev.dy = '0;
            ev.btn = 1'b1;
            ev.last = 1'b1;
            expected_events.push_back(ev);
        end
    endtask

    task automatic check_field(input string fname, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h",
                     $time, fname, want, got);
            mismatch_count++;
        end
    endtask

    // Byte sender: in bursty phases, bursts of random length separated by random gaps; else back to back.
    always @(negedge clk) begin : byte_sender
        mouse_byte_t nxt;
        int          burst_left;
        int          gap_left;
        if (!rst_n) begin
            in_valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end else if (!in_valid || in_fire) begin
            if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
                nxt = pending_bytes.pop_front();
                in_valid <= 1'b1;
                rx_byte <= nxt.data;
                from_aux <= nxt.aux;
                if (sender_bursty) begin
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 12);
                        gap_left = $urandom_range(1, 8);
                    end
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Event receiver: always ready, randomly ready, or alternating runs.
    always @(negedge clk) begin : event_receiver
        bit ready_run;
        int run_left;
        if (!rst_n) begin
            out_ready <= 1'b0;
            ready_run = 1'b1;
            run_left = 0;
        end else if (ready_style == READY_ALWAYS) begin
            out_ready <= 1'b1;
        end else if (ready_style == READY_RANDOM) begin
            out_ready <= ($urandom_range(0, 2) != 0);
        end else begin
            if (run_left == 0) begin
                ready_run = !ready_run;
                run_left = ready_run ? $urandom_range(1, 6) : $urandom_range(1, 10);
            end else begin
                run_left--;
            end
            out_ready <= ready_run;
        end
    end

    // Monitor: predict on byte transfers, track limit writes, check events.
    always @(posedge clk) begin : event_monitor
        cursor_event_t ev;
        bit            cfg_fire;
        bit            out_fire;
        if (rst_n) begin
            in_fire = in_valid && in_ready;
            cfg_fire = cfg_valid && cfg_ready;
            out_fire = out_valid && out_ready;
            if (in_fire) begin
                bytes_taken++;
                absorb_byte(rx_byte, from_aux);
            end
            if (cfg_fire) begin
                limit_writes++;
                if (cfg_index == CFG_X_LIMIT)
                    x_lim = cfg_data;
                else if (cfg_index == CFG_Y_LIMIT)
                    y_lim = cfg_data;
            end
            if (out_fire) begin
                if (expected_events.size() == 0) begin
                    $display("%0t ns: unexpected event, expected none, got kind %0d x %0d y %0d",
                             $time, event_kind, cursor_x, cursor_y);
                    mismatch_count++;
                end else begin
                    ev = expected_events.pop_front();
                    check_field("event_kind", 16'(ev.kind), 16'(event_kind));
                    check_field("cursor_x", 16'(ev.cx), 16'(cursor_x));
                    check_field("cursor_y", 16'(ev.cy), 16'(cursor_y));
                    check_field("delta_x", 16'(ev.dx), 16'(delta_x));
                    check_field("delta_y", 16'(ev.dy), 16'(delta_y));
                    check_field("button_id", 16'(ev.btn), 16'(button_id));
                    check_field("last_event", 16'(ev.last), 16'(last_event));
                    if (ev.kind == EV_MOVE)
                        moves_checked++;
                    else
                        buttons_checked++;
                end
            end

            // Watchdog on a stalled interface.
            if (in_fire || cfg_fire || out_fire)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t ns: no transfer for %0d cycles, %0d events outstanding",
                         $time, idle_cycles, expected_events.size());
                $display("== FAIL ==");
                $finish;
            end
        end else begin
            in_fire = 1'b0;
        end
    end

    task automatic push_byte(input logic [7:0] data, input logic aux);
        mouse_byte_t item;
        item.data = data;
        item.aux = aux;
        pending_bytes.push_back(item);
    endtask

    // Queue a packet, sometimes with keyboard bytes slipped between its bytes.
    task automatic push_packet(input logic [7:0] hdr, input logic [7:0] xb,
                               input logic [7:0] yb, input bit noisy);
        push_byte(hdr, 1'b1);
        if (noisy && $urandom_range(0, 9) == 0)
            push_byte(8'($urandom_range(0, 255)), 1'b0);
        push_byte(xb, 1'b1);
        if (noisy && $urandom_range(0, 9) == 0)
            push_byte(8'($urandom_range(0, 255)), 1'b0);
        push_byte(yb, 1'b1);
    endtask

    // Wait until every queued byte is sent and every event has come back.
    task automatic wait_drained();
        while (pending_bytes.size() != 0 || in_valid || expected_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Limit write; valid stays up for back-to-back writes until lowered.
    task automatic write_limit(input logic [CFG_IDX_BITS-1:0] idx,
                               input logic [LIMIT_BITS-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    initial begin : stimulus
        int          counted;
        int          pick;
        int          lim;
        logic [7:0]  hdr;
        logic [7:0]  xb;
        logic [7:0]  yb;
        drift_t      drift;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset limits.
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_packet(8'h08, 8'hFF, 8'hFF, 1'b0);   // largest positive deltas
        push_packet(8'h39, 8'h00, 8'h00, 1'b0);   // left down, largest negative deltas
        push_packet(8'hC9, 8'h01, 8'hFF, 1'b0);   // overflow bits set, left held
        // Left up with middle and right down; keyboard bytes inside the packet.
        push_byte(8'h0E, 1'b1);
        push_byte(8'hAA, 1'b0);
        push_byte(8'h7F, 1'b1);
        push_byte(8'h55, 1'b0);
        push_byte(8'h80, 1'b1);
        push_packet(8'h0C, 8'h00, 8'h00, 1'b0);   // right released alone, no motion
        push_packet(8'h18, 8'h80, 8'h7F, 1'b0);
        push_packet(8'h29, 8'h7F, 8'h80, 1'b0);   // left down again
        wait_drained();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            // Reprogram the limits while the block is idle.
            lim = X_LIMIT_PLAN[ph];
            if (lim == RANDOM_LIMIT)
                lim = $urandom_range(0, 4095);
            write_limit(CFG_X_LIMIT, lim[LIMIT_BITS-1:0]);
            lim = Y_LIMIT_PLAN[ph];
            if (lim == RANDOM_LIMIT)
                lim = $urandom_range(0, 4095);
            write_limit(CFG_Y_LIMIT, lim[LIMIT_BITS-1:0]);
            if (ph % 4 == 1)
                write_limit(CFG_IDX_SPARE_A, 12'($urandom_range(0, 4095)));
            else if (ph % 4 == 3)
                write_limit(CFG_IDX_SPARE_B, 12'($urandom_range(0, 4095)));
            @(negedge clk);
            cfg_valid <= 1'b0;

            sender_bursty = (ph % 3 != 0);
            ready_style = ready_style_t'((ph + 1) % 3);
            drift = DRIFT_PLAN[ph];

            // Mostly whole packets, with keyboard noise and stray mouse bytes.
            counted = 0;
            while (counted < ITEMS_PER_PHASE) begin
                pick = $urandom_range(0, 19);
                if (pick < 2) begin
                    push_byte(8'($urandom_range(0, 255)), 1'b0);
                end else if (pick < 4) begin
                    push_byte(8'($urandom_range(0, 255)), 1'b1);
                    counted++;
                end else begin
                    hdr = 8'($urandom_range(0, 255));
                    xb = 8'($urandom_range(0, 255));
                    yb = 8'($urandom_range(0, 255));
                    if (drift != DRIFT_NONE && $urandom_range(0, 3) != 0) begin
                        hdr[HDR_XSIGN] = (drift == DRIFT_DOWN);
                        hdr[HDR_YSIGN] = (drift == DRIFT_DOWN);
                        xb[7] = (drift == DRIFT_UP);
                        yb[7] = (drift == DRIFT_UP);
                    end
                    push_packet(hdr, xb, yb, 1'b1);
                    counted += 3;
                end
            end
            wait_drained();
        end

        $display("Run covered %0d byte transfers (%0d keyboard bytes ignored) and %0d limit writes.",
                 bytes_taken, bytes_ignored, limit_writes);
        $display("Checked %0d move events and %0d left button events, %0d left waiting.",
                 moves_checked, buttons_checked, expected_events.size());
        if (mismatch_count == 0 && expected_events.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
